// ===== rtl/vdto_pkg.sv =====
// package for the variable duty triangle oscillator
// widths, reset values, opcodes and controller states; no dependencies
package vdto_pkg;

  localparam int OUT_FRAC_BITS = 16;
  localparam int SAMPLE_W      = OUT_FRAC_BITS + 2;
  localparam int OUT_SHIFT     = 32 - OUT_FRAC_BITS;

  localparam int FREQ_W  = 32;
  localparam int DUTY_W  = 18;
  localparam int NPH_W   = 34;
  localparam int SP_W    = 32;
  localparam int PH_W    = 33;
  localparam int DEN_W   = 16;
  localparam int MAG_W   = 53;
  localparam int V_W     = 35;

  localparam int ITER    = 33;
  localparam int CNT_W   = $clog2(ITER);

  localparam logic [PH_W-1:0] PH_ONE    = {1'b1, {(PH_W-1){1'b0}}};
  localparam logic [SP_W-1:0] SP_RESET  = 32'd89478;
  localparam logic [V_W-1:0]  OUT_HALF  = V_W'(64'd1 << (OUT_SHIFT - 1));

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

endpackage

// ===== rtl/vdto_if.sv =====
// channel interfaces for the variable duty triangle oscillator
// depends on vdto_pkg for field widths
interface vdto_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [vdto_pkg::FREQ_W-1:0]   freq;
  logic [vdto_pkg::DUTY_W-1:0]   duty;
  logic [vdto_pkg::NPH_W-1:0]    new_phase;

  modport source (output valid, opcode, freq, duty, new_phase, input ready);
  modport sink   (input valid, opcode, freq, duty, new_phase, output ready);
endinterface

interface vdto_out_if;
  logic                          valid;
  logic                          ready;
  logic [vdto_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

interface vdto_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [vdto_pkg::SP_W-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/variable_duty_triangle_oscillator.sv =====
// variable duty triangle oscillator: phase accumulator with bit-serial
// multiplier and restoring divider; depends on vdto_pkg and vdto_if
//
//   channel  dir  words                    handshake
//   in_i     in   opcode freq duty phase   valid/ready
//   out_o    out  sample                   valid/ready
//   cfg_i    in   sample_period            valid/ready, always ready
//
// a set word loads the phase on accept; a tick word runs accept, 33
// shift steps of the shared bit counter (one multiplier bit and one
// quotient bit per step), then the finish state
// the finish state waits while the output register holds an untaken sample
// reset clears the phase, loads the default sample period and empties output
module variable_duty_triangle_oscillator (
  input  logic clk_i,
  input  logic rst_ni,
  vdto_in_if.sink    in_i,
  vdto_out_if.source out_o,
  vdto_cfg_if.sink   cfg_i
);

  vdto_pkg::state_e state_q, state_d;

  logic [vdto_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [vdto_pkg::SP_W-1:0]     sp_q;
  logic [vdto_pkg::PH_W-1:0]     phase_q, phase_d;
  logic [vdto_pkg::SP_W-1:0]     prod_hi_q, prod_hi_d;
  logic [vdto_pkg::ITER-1:0]     prod_lo_q, prod_lo_d;
  logic [vdto_pkg::DEN_W-1:0]    rem_q, rem_d;
  logic [vdto_pkg::DEN_W-1:0]    den_q, den_d;
  logic [vdto_pkg::PH_W-1:0]     quo_q, quo_d;
  logic                          div_en_q, div_en_d;
  logic                          neg_q, neg_d;
  logic                          out_valid_q, out_valid_d;
  logic [vdto_pkg::SAMPLE_W-1:0] sample_q, sample_d;

  logic                          accept;
  logic                          d_le0, d_ge1, rising;
  logic [vdto_pkg::DEN_W-1:0]    d16;
  logic [vdto_pkg::PH_W-1:0]     x_val, r_val;
  logic [vdto_pkg::FREQ_W-1:0]   fmag;
  logic [vdto_pkg::PH_W-1:0]     np_clamp;
  logic [vdto_pkg::SP_W:0]       mac_sum;
  logic [vdto_pkg::DEN_W:0]      rem2;
  logic                          ge;
  logic [vdto_pkg::MAG_W-1:0]    mag12;
  logic                          up;
  logic [vdto_pkg::MAG_W:0]      psum, pdiff;
  logic [vdto_pkg::V_W-1:0]      v_val;

  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.sample = sample_q;

  // duty classification and divider operands
  assign d_le0  = in_i.duty[vdto_pkg::DUTY_W-1] || (in_i.duty == '0);
  assign d_ge1  = !in_i.duty[vdto_pkg::DUTY_W-1] && in_i.duty[vdto_pkg::DEN_W];
  assign d16    = in_i.duty[vdto_pkg::DEN_W-1:0];
  assign rising = phase_q < {1'b0, d16, {vdto_pkg::DEN_W{1'b0}}};
  assign x_val  = rising ? phase_q : vdto_pkg::PH_ONE - phase_q;
  assign r_val  = d_ge1 ? phase_q : vdto_pkg::PH_ONE - phase_q;
  assign fmag   = in_i.freq[vdto_pkg::FREQ_W-1] ? (~in_i.freq + 1'b1) : in_i.freq;

  always_comb begin
    if (in_i.new_phase[vdto_pkg::NPH_W-1]) begin
      np_clamp = '0;
    end else if (in_i.new_phase[vdto_pkg::NPH_W-2:0] > vdto_pkg::PH_ONE) begin
      np_clamp = vdto_pkg::PH_ONE;
    end else begin
      np_clamp = in_i.new_phase[vdto_pkg::PH_W-1:0];
    end
  end

  // one multiplier bit and one quotient bit per step
  assign mac_sum = {1'b0, prod_hi_q} + (prod_lo_q[0] ? {1'b0, sp_q} : '0);
  assign rem2    = {rem_q, quo_q[vdto_pkg::PH_W-1]};
  assign ge      = rem2 >= {1'b0, den_q};

  // phase step and sample from finished product and quotient
  assign mag12 = {prod_hi_q, prod_lo_q[vdto_pkg::ITER-1:12]};
  assign up    = |prod_lo_q[11:0];
  assign psum  = {{(vdto_pkg::MAG_W-vdto_pkg::PH_W+1){1'b0}}, phase_q} + {1'b0, mag12};
  assign pdiff = {{(vdto_pkg::MAG_W-vdto_pkg::PH_W+1){1'b0}}, phase_q} - {1'b0, mag12}
                 - {{vdto_pkg::MAG_W{1'b0}}, up};
  assign v_val = {1'b0, quo_q, 1'b0} - {2'b00, vdto_pkg::PH_ONE} + vdto_pkg::OUT_HALF;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    prod_hi_d   = prod_hi_q;
    prod_lo_d   = prod_lo_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quo_d       = quo_q;
    div_en_d    = div_en_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_o.ready;
    sample_d    = sample_q;
    in_i.ready  = 1'b0;
    unique case (state_q)
      vdto_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (accept) begin
          if (in_i.opcode == vdto_pkg::OP_SET) begin
            phase_d = np_clamp;
          end else begin
            state_d   = vdto_pkg::ST_RUN;
            cnt_d     = '0;
            prod_hi_d = '0;
            prod_lo_d = {1'b0, fmag};
            neg_d     = in_i.freq[vdto_pkg::FREQ_W-1];
            den_d     = ~d16 + 1'b1;
            if (rising) begin
              den_d = d16;
            end
            if (d_le0 || d_ge1) begin
              div_en_d = 1'b0;
              rem_d    = '0;
              quo_d    = r_val;
            end else begin
              div_en_d = 1'b1;
              rem_d    = x_val[vdto_pkg::PH_W-1:vdto_pkg::PH_W-vdto_pkg::DEN_W];
              quo_d    = {x_val[vdto_pkg::PH_W-vdto_pkg::DEN_W-1:0], {vdto_pkg::DEN_W{1'b0}}};
            end
          end
        end
      end
      vdto_pkg::ST_RUN: begin
        prod_hi_d = mac_sum[vdto_pkg::SP_W:1];
        prod_lo_d = {mac_sum[0], prod_lo_q[vdto_pkg::ITER-1:1]};
        if (div_en_q) begin
          quo_d = {quo_q[vdto_pkg::PH_W-2:0], ge};
          rem_d = ge ? rem2[vdto_pkg::DEN_W-1:0] - den_q : rem2[vdto_pkg::DEN_W-1:0];
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == vdto_pkg::CNT_W'(vdto_pkg::ITER - 1)) begin
          state_d = vdto_pkg::ST_FIN;
        end
      end
      vdto_pkg::ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          sample_d    = v_val[vdto_pkg::OUT_SHIFT+vdto_pkg::SAMPLE_W-1:vdto_pkg::OUT_SHIFT];
          state_d     = vdto_pkg::ST_IDLE;
          if (neg_q) begin
            phase_d = pdiff[vdto_pkg::MAG_W] ? vdto_pkg::PH_ONE : pdiff[vdto_pkg::PH_W-1:0];
          end else begin
            phase_d = (psum > {{(vdto_pkg::MAG_W-vdto_pkg::PH_W+1){1'b0}}, vdto_pkg::PH_ONE})
                      ? '0 : psum[vdto_pkg::PH_W-1:0];
          end
        end
      end
      default: begin
        state_d = vdto_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vdto_pkg::ST_IDLE;
      cnt_q       <= '0;
      sp_q        <= vdto_pkg::SP_RESET;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      div_en_q    <= 1'b0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      div_en_q    <= div_en_d;
      neg_q       <= neg_d;
      if (cfg_i.valid && cfg_i.ready) begin
        sp_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_hi_q <= prod_hi_d;
    prod_lo_q <= prod_lo_d;
    rem_q     <= rem_d;
    den_q     <= den_d;
    quo_q     <= quo_d;
    sample_q  <= sample_d;
  end

endmodule

// ===== dv/variable_duty_triangle_oscillator_tb.sv =====
// self-checking bench for the variable duty triangle oscillator
// predicts every sample in a small scoreboard class and drives the in and out
// valid/ready channels with random gaps; needs vdto_pkg, vdto_if and the rtl
`timescale 1ns / 100ps

module variable_duty_triangle_oscillator_tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam longint PH_SPAN = 64'sd1 <<< 32;
  localparam longint DUTY_SPAN = 64'sd1 <<< 16;

  typedef struct {
    vdto_pkg::opcode_e           op;
    logic [vdto_pkg::FREQ_W-1:0] freq;
    logic [vdto_pkg::DUTY_W-1:0] duty;
    logic [vdto_pkg::NPH_W-1:0]  new_phase;
  } osc_word_t;

  class sample_predictor;
    logic [vdto_pkg::SP_W-1:0]     period = vdto_pkg::SP_RESET;
    logic [vdto_pkg::PH_W-1:0]     phase = '0;
    logic [vdto_pkg::SAMPLE_W-1:0] expected_samples[$];
    int errors = 0;
    int n_ticks = 0;
    int n_sets = 0;
    int n_checked = 0;

    function void take_word(osc_word_t w);
      longint p, dd, v, r, biased, np, inc, ff;
      logic [63:0] a, mag;
      if (w.op == vdto_pkg::OP_SET) begin
        np = longint'($signed(w.new_phase));
        if (np < 0) np = 0;
        if (np > PH_SPAN) np = PH_SPAN;
        phase = vdto_pkg::PH_W'(np);
        n_sets++;
        return;
      end
      p = longint'(phase);
      dd = longint'($signed(w.duty));
      // sample from the current phase
      if (dd <= 0) begin
        v = PH_SPAN - 2 * p;
      end else if (dd >= DUTY_SPAN) begin
        v = 2 * p - PH_SPAN;
      end else if (p < (dd <<< 16)) begin
        r = (p <<< 16) / dd;
        v = 2 * r - PH_SPAN;
      end else begin
        r = ((PH_SPAN - p) <<< 16) / (DUTY_SPAN - dd);
        v = 2 * r - PH_SPAN;
      end
      biased = v + (PH_SPAN <<< 1) + (longint'(1) <<< (vdto_pkg::OUT_SHIFT - 1));
      expected_samples.push_back(
        vdto_pkg::SAMPLE_W'((biased >>> vdto_pkg::OUT_SHIFT)
                            - (longint'(1) <<< (vdto_pkg::OUT_FRAC_BITS + 1))));
      // phase step, negative steps round away from zero
      ff = longint'($signed(w.freq));
      a = (ff < 0) ? -ff : ff;
      mag = a * {32'd0, period};
      inc = (ff < 0) ? -longint'((mag + 64'd4095) >> 12) : longint'(mag >> 12);
      p = p + inc;
      if (p < 0) p = PH_SPAN;
      else if (p > PH_SPAN) p = 0;
      phase = vdto_pkg::PH_W'(p);
      n_ticks++;
    endfunction

    function void check_sample(logic [vdto_pkg::SAMPLE_W-1:0] got);
      logic [vdto_pkg::SAMPLE_W-1:0] want;
      if (expected_samples.size() == 0) begin
        $error("sample: none expected, got %0d", $signed(got));
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      n_checked++;
      if (got !== want) begin
        $error("sample: expected %0d, got %0d", $signed(want), $signed(got));
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   steady = 1'b0;
  int   idle_cycles = 0;
  int   n_cfg = 0;

  sample_predictor model = new();

  vdto_in_if  in_if();
  vdto_out_if out_if();
  vdto_cfg_if cfg_if();

  variable_duty_triangle_oscillator DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(21, 80);
  endfunction

  function automatic logic [vdto_pkg::FREQ_W-1:0] rand_freq();
    logic [vdto_pkg::FREQ_W-1:0] f;
    case ($urandom_range(0, 3))
      0: f = $urandom();
      1: begin
        f = $urandom_range(0, 24000 * 4096);
        if ($urandom_range(0, 1) == 1) f = -f;
      end
      2: f = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      default: begin
        case ($urandom_range(0, 4))
          0: f = 32'h7FFF_FFFF;
          1: f = 32'h8000_0000;
          2: f = '0;
          3: f = 32'd1;
          default: f = '1;
        endcase
      end
    endcase
    return f;
  endfunction

  function automatic osc_word_t random_word();
    osc_word_t w;
    w.op = ($urandom_range(0, 99) < 15) ? vdto_pkg::OP_SET : vdto_pkg::OP_TICK;
    w.freq = rand_freq();
    case ($urandom_range(0, 3))
      0: w.duty = vdto_pkg::DUTY_W'($urandom());
      1, 2: w.duty = vdto_pkg::DUTY_W'($urandom_range(0, 65536));
      default: begin
        case ($urandom_range(0, 6))
          0: w.duty = '0;
          1: w.duty = 18'd1;
          2: w.duty = 18'd65535;
          3: w.duty = 18'd65536;
          4: w.duty = '1;
          5: w.duty = 18'h1FFFF;
          default: w.duty = 18'h20000;
        endcase
      end
    endcase
    case ($urandom_range(0, 3))
      0: w.new_phase = vdto_pkg::NPH_W'({$urandom(), $urandom()});
      1, 2: begin
        if ($urandom_range(0, 15) == 0) w.new_phase = 34'h1_0000_0000;
        else w.new_phase = {2'b00, 32'($urandom())};
      end
      default: begin
        case ($urandom_range(0, 6))
          0: w.new_phase = '0;
          1: w.new_phase = 34'h1_0000_0000;
          2: w.new_phase = 34'h1_0000_0001;
          3: w.new_phase = 34'h0_FFFF_FFFF;
          4: w.new_phase = '1;
          5: w.new_phase = 34'h2_0000_0000;
          default: w.new_phase = 34'h1_FFFF_FFFF;
        endcase
      end
    endcase
    return w;
  endfunction

  // called and returns at a falling edge
  task automatic send_word(osc_word_t w);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.opcode    <= w.op;
    in_if.freq      <= w.freq;
    in_if.duty      <= w.duty;
    in_if.new_phase <= w.new_phase;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    model.take_word(w);
    @(negedge clk_i);
  endtask

  task automatic write_period(logic [vdto_pkg::SP_W-1:0] sp);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= sp;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    model.period = sp;
    n_cfg++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // drain all samples, then give a trailing set word time to land
  task automatic settle();
    in_if.valid <= 1'b0;
    while (model.expected_samples.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_directed();
    send_word('{vdto_pkg::OP_TICK, 32'd0, 18'd0, 34'd0});
    send_word('{vdto_pkg::OP_SET, 32'd0, 18'd0, 34'h2_0000_0000});
    send_word('{vdto_pkg::OP_TICK, 32'd0, 18'd65536, 34'd0});
    send_word('{vdto_pkg::OP_SET, 32'd0, 18'd0, 34'h1_FFFF_FFFF});
    send_word('{vdto_pkg::OP_TICK, 32'd0, 18'd65536, 34'd0});
    send_word('{vdto_pkg::OP_TICK, 32'd0, 18'h1FFFF, 34'd0});
    send_word('{vdto_pkg::OP_TICK, 32'd0, 18'h20000, 34'd0});
    send_word('{vdto_pkg::OP_TICK, 32'd0, 18'd32768, 34'd0});
    send_word('{vdto_pkg::OP_SET, 32'd0, 18'd0, 34'h1_0000_0001});
    // wrap past one, then below zero
    send_word('{vdto_pkg::OP_TICK, 32'd1, 18'd0, 34'd0});
    send_word('{vdto_pkg::OP_TICK, '1, 18'd1, 34'd0});
    send_word('{vdto_pkg::OP_TICK, 32'h7FFF_FFFF, 18'd65535, 34'd0});
    send_word('{vdto_pkg::OP_TICK, 32'h8000_0000, 18'd1, 34'd0});
    // phase on and just under the rise/fall corner
    send_word('{vdto_pkg::OP_SET, 32'd0, 18'd0, 34'h0_8000_0000});
    send_word('{vdto_pkg::OP_TICK, 32'd0, 18'd32768, 34'd0});
    send_word('{vdto_pkg::OP_SET, 32'd0, 18'd0, 34'h0_7FFF_FFFF});
    send_word('{vdto_pkg::OP_TICK, 32'd0, 18'd32768, 34'd0});
    send_word('{vdto_pkg::OP_SET, 32'd0, 18'd0, 34'd0});
    send_word('{vdto_pkg::OP_TICK, 32'd98304000, '1, 34'd0});
    send_word('{vdto_pkg::OP_TICK, -32'sd1802240, 18'd16384, 34'd0});
    send_word('{vdto_pkg::OP_SET, 32'd0, 18'd0, 34'h0_5555_5555});
    send_word('{vdto_pkg::OP_TICK, 32'h1234_5678, 18'd1, 34'd0});
  endtask

  task automatic run_random(int n);
    osc_word_t w;
    int sent, d, off;
    sent = 0;
    while (sent < n) begin
      w = random_word();
      if ($urandom_range(0, 99) < 8) begin
        // land on the corner of a random duty, then tick with that duty
        d = $urandom_range(1, 65535);
        off = int'($urandom_range(0, 2)) - 1;
        w.op = vdto_pkg::OP_SET;
        w.new_phase = vdto_pkg::NPH_W'((longint'(d) <<< 16) + off);
        send_word(w);
        sent++;
        w.op = vdto_pkg::OP_TICK;
        w.duty = vdto_pkg::DUTY_W'(d);
        w.freq = rand_freq();
      end
      send_word(w);
      sent++;
    end
  endtask

  initial begin : sample_sink
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        if (!steady) stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready) model.check_sample(out_if.sample);
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready === 1'b1) || (out_if.valid === 1'b1 && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.opcode     = 1'b0;
    in_if.freq       = '0;
    in_if.duty       = '0;
    in_if.new_phase  = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    run_random(300);
    settle();

    steady = 1'b1;
    write_period('1);
    run_random(300);
    settle();

    steady = 1'b0;
    write_period('0);
    run_random(200);
    settle();

    write_period(32'd1);
    run_random(200);
    settle();

    write_period($urandom());
    run_random(300);
    settle();

    write_period(32'd44739);
    run_random(500);
    settle();

    $display("%0d tick and %0d set words sent over %0d period writes",
             model.n_ticks, model.n_sets, n_cfg);
    $display("%0d samples compared, %0d mismatches", model.n_checked, model.errors);
    if (model.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
